// ===== src/lcdpw_pkg.sv =====
// Shared types and constants for the LCD controller pixel writer.
// No dependencies; the other files but lcdpw_frame_bank refer to it by scoped names.
`default_nettype none

package lcdpw_pkg;

    // request kinds on the input stream (tuser[1:0])
    localparam logic [1:0] CMD_BUS_READ   = 2'd0;
    localparam logic [1:0] CMD_BUS_WRITE  = 2'd1;
    localparam logic [1:0] CMD_FRAME_READ = 2'd2;

    // data port targets, index register bits 2..0
    localparam logic [2:0] IDX_PIXEL    = 3'd0;
    localparam logic [2:0] IDX_COLUMN   = 3'd1;
    localparam logic [2:0] IDX_ROW      = 3'd2;
    localparam logic [2:0] IDX_FUNCTION = 3'd3;

    localparam int FUNC_MODE6_BIT    = 6;
    localparam int FUNC_COL_STEP_BIT = 7;

    localparam int LINES           = 32;
    localparam int HALF_SHIFT      = 96;
    localparam int MODE6_FIRST_COL = 6;
    localparam int MODE8_FIRST_COL = 4;
    localparam int MODE8_LEAD      = 4;

    // pixel x position and byte address, two's complement
    localparam int XW   = 13;
    localparam int AW_S = 14;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    typedef enum logic [1:0] {
        K_NONE,
        K_REG,
        K_FRAME,
        K_PIXEL
    } t_kind;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_result;

endpackage

`default_nettype wire

// ===== src/lcdpw_frame_bank.sv =====
// One bank of the bit-packed frame store: one write port, one read port,
// registered read data (old data on a same-cycle write). No dependencies.
`default_nettype none

module lcdpw_frame_bank #(
    parameter int DEPTH = 384,
    parameter int AW    = 9
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/lcdpw_out_fifo.sv =====
// Small result queue between the frame pipeline and the output stream.
// Depends on lcdpw_pkg for its depth and the result struct.
`default_nettype none

module lcdpw_out_fifo (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire lcdpw_pkg::t_result            i_push,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [7:0]                         o_data,
    output logic [lcdpw_pkg::FIFO_CW-1:0]      o_count
);

    logic [7:0]                      r_mem [lcdpw_pkg::FIFO_DEPTH];
    logic [lcdpw_pkg::FIFO_AW-1:0]   r_wp;
    logic [lcdpw_pkg::FIFO_AW-1:0]   r_rp;
    logic [lcdpw_pkg::FIFO_CW-1:0]   r_cnt;
    logic [lcdpw_pkg::FIFO_CW-1:0]   n_cnt;
    logic                            w_pop;

    assign o_valid = (r_cnt != '0);
    assign w_pop   = o_valid && i_ready;
    assign o_data  = r_mem[r_rp];
    assign o_count = r_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push.valid && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push.valid && w_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.valid) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wp] <= i_push.data;
        end
    end

endmodule

`default_nettype wire

// ===== src/lcd_controller_pixel_writer_unit.sv =====
// LCD controller pixel writer: register file, three-stage frame pipeline.
// Depends on lcdpw_pkg, lcdpw_frame_bank and lcdpw_out_fifo.
//
// Input stream s_axis: one bus access or display fetch per request.
//   tuser = cmd (0 bus read, 1 bus write, 2 frame read), port_odd.
//   tdata = write_data, frame_addr.
// Output stream m_axis: read_data, one result per bus read or frame read;
// bus writes and the unused cmd 3 give none. Results leave in request order.
// Throughput: one request per cycle while s_axis_tready is high; register
// writes take effect at once. Results pass the stage 1 and 2 registers.
// Pixel writes read-modify-write two frame bytes; the store is split into
// an even-byte and an odd-byte bank so both bytes go in one pass. Write
// data of the previous cycle is forwarded to the read stage.
// A four-entry output queue decouples the sink: s_axis_tready drops in the
// clearing pass and when queued plus in-flight results would overfill it,
// so the pipeline itself never stalls.
// Reset: registers clear, then a clearing pass zeroes the frame store,
// one address of each bank per cycle over FRAME_WIDTH*2 addresses (384 at the
// default width); s_axis_tready stays low until it ends.
`default_nettype none

module lcd_controller_pixel_writer_unit #(
    parameter int FRAME_WIDTH  = 192,
    parameter int COLUMN_LIMIT = 22,
    parameter int ROW_LIMIT    = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // write_data[7:0], frame_addr[17:8]
    input  wire logic [2:0]  s_axis_tuser,   // cmd[1:0], port_odd[2]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata    // read_data[7:0]
);

    localparam int LINE_BYTES  = FRAME_WIDTH / 8;
    localparam int STORE_BYTES = LINE_BYTES * lcdpw_pkg::LINES;
    localparam int BANK_DEPTH  = STORE_BYTES / 2;
    localparam int BANK_AW     = $clog2(BANK_DEPTH);
    localparam int XW          = lcdpw_pkg::XW;
    localparam int AW_S        = lcdpw_pkg::AW_S;

    // register file
    logic [7:0] r_index, n_index;
    logic [7:0] r_col, n_col;
    logic [7:0] r_row, n_row;
    logic [7:0] r_func, n_func;

    // stage 1
    lcdpw_pkg::t_kind r_s1_kind, n_s1_kind;
    logic [7:0]       r_s1_data, n_s1_data;
    logic [XW-1:0]    r_s1_x0;
    logic [4:0]       r_s1_y;
    logic [7:0]       r_s1_bits;
    logic [7:0]       r_s1_en;
    logic [9:0]       r_s1_faddr;

    // stage 2
    lcdpw_pkg::t_kind r_s2_kind;
    logic [7:0]       r_s2_data;
    logic [7:0]       r_s2_m0, r_s2_m1, r_s2_d0, r_s2_d1;
    logic [BANK_AW-1:0] r_s2_ix0, r_s2_ix1;
    logic             r_s2_fsel;
    logic             r_s2_fok;

    // forwarding of last cycle's bank writes
    logic               r_fw0_v, r_fw1_v;
    logic [BANK_AW-1:0] r_fw0_ix, r_fw1_ix;
    logic [7:0]         r_fw0_d, r_fw1_d;

    // clearing pass
    logic               r_clr_busy;
    logic [BANK_AW-1:0] r_clr_ix;

    logic       w_acc;
    logic [1:0] w_cmd;
    logic       w_odd;
    logic [7:0] w_wdata;
    logic [9:0] w_faddr;
    logic       w_mode6;
    logic       w_hit;
    logic [XW-1:0] w_half, w_x0;
    logic [7:0] w_bits, w_en;

    logic [7:0]         w_m0, w_m1, w_d0, w_d1;
    logic [BANK_AW-1:0] w_ix0, w_ix1;
    logic               w_fsel, w_fok;

    logic [7:0] w_rd0, w_rd1, w_cur0, w_cur1, w_new0, w_new1;
    logic       w_we0, w_we1;
    logic       w_bwe0, w_bwe1;
    logic [BANK_AW-1:0] w_bwa0, w_bwa1;
    logic [7:0] w_bwd0, w_bwd1;

    lcdpw_pkg::t_result           w_push;
    logic [lcdpw_pkg::FIFO_CW-1:0] w_fifo_cnt;
    logic [lcdpw_pkg::FIFO_CW:0]   w_load;

    assign w_cmd   = s_axis_tuser[1:0];
    assign w_odd   = s_axis_tuser[2];
    assign w_wdata = s_axis_tdata[7:0];
    assign w_faddr = s_axis_tdata[17:8];
    assign w_acc   = s_axis_tvalid && s_axis_tready;

    // ---------------- accept stage: registers and pixel geometry
    assign w_mode6 = r_func[lcdpw_pkg::FUNC_MODE6_BIT];
    assign w_hit   = ({1'b0, r_col} < 9'(COLUMN_LIMIT)) && ({1'b0, r_row} < 9'(ROW_LIMIT))
                     && (w_mode6 ? (r_col >= 8'(lcdpw_pkg::MODE6_FIRST_COL))
                                 : (r_col >= 8'(lcdpw_pkg::MODE8_FIRST_COL)));
    assign w_half  = XW'(r_row[7:5]) * XW'(lcdpw_pkg::HALF_SHIFT);
    assign w_x0    = w_mode6
        ? w_half + XW'(r_col - 8'(lcdpw_pkg::MODE6_FIRST_COL)) * XW'(6)
        : w_half + (XW'(r_col - 8'(lcdpw_pkg::MODE8_FIRST_COL)) << 3)
                 - XW'(lcdpw_pkg::MODE8_LEAD);
    assign w_bits  = w_mode6 ? {w_wdata[5:0], 2'b00} : w_wdata;
    assign w_en    = w_mode6 ? 8'b1111_1100 : 8'hFF;

    always_comb begin
        n_index   = r_index;
        n_col     = r_col;
        n_row     = r_row;
        n_func    = r_func;
        n_s1_kind = lcdpw_pkg::K_NONE;
        n_s1_data = r_index;
        if (w_acc) begin
            unique case (w_cmd)
                lcdpw_pkg::CMD_BUS_READ: begin
                    n_s1_kind = lcdpw_pkg::K_REG;
                    n_s1_data = w_odd ? 8'h00 : r_index;
                end
                lcdpw_pkg::CMD_BUS_WRITE: begin
                    if (!w_odd) begin
                        n_index = w_wdata;
                    end else begin
                        unique case (r_index[2:0])
                            lcdpw_pkg::IDX_PIXEL: begin
                                n_s1_kind = w_hit ? lcdpw_pkg::K_PIXEL : lcdpw_pkg::K_NONE;
                                if (r_func[lcdpw_pkg::FUNC_COL_STEP_BIT]) begin
                                    n_col = r_col + 8'd1;
                                end else begin
                                    n_row = r_row + 8'd1;
                                end
                            end
                            lcdpw_pkg::IDX_COLUMN:   n_col  = w_wdata;
                            lcdpw_pkg::IDX_ROW:      n_row  = w_wdata;
                            lcdpw_pkg::IDX_FUNCTION: n_func = w_wdata;
                            default: ;
                        endcase
                    end
                end
                lcdpw_pkg::CMD_FRAME_READ: n_s1_kind = lcdpw_pkg::K_FRAME;
                default: ;
            endcase
        end
    end

    // ---------------- stage 1: clip, byte addresses, bank reads
    always_comb begin
        logic [7:0]      ok;
        logic [XW-1:0]   xk;
        logic [15:0]     span_bits, span_en;
        logic [AW_S-1:0] b0, a0, a1, a_even, a_odd, fa;
        logic [7:0]      m0, m1;
        for (int k = 0; k < 8; k++) begin
            xk        = r_s1_x0 + XW'(k);
            ok[7 - k] = (xk < XW'(FRAME_WIDTH));   // negative x wraps high
        end
        span_bits = {r_s1_bits, 8'h00} >> r_s1_x0[2:0];
        span_en   = {r_s1_en & ok, 8'h00} >> r_s1_x0[2:0];
        b0 = {{(AW_S - XW + 3){r_s1_x0[XW-1]}}, r_s1_x0[XW-1:3]};
        a0 = AW_S'(r_s1_y) * AW_S'(LINE_BYTES) + b0;
        a1 = a0 + AW_S'(1);
        m0 = (a0 < AW_S'(STORE_BYTES)) ? span_en[15:8] : 8'h00;
        m1 = (a1 < AW_S'(STORE_BYTES)) ? span_en[7:0]  : 8'h00;
        a_even = a0[0] ? a1 : a0;
        a_odd  = a0[0] ? a0 : a1;
        fa     = AW_S'(r_s1_faddr);
        w_m0   = a0[0] ? m1 : m0;
        w_m1   = a0[0] ? m0 : m1;
        w_d0   = a0[0] ? span_bits[7:0]  : span_bits[15:8];
        w_d1   = a0[0] ? span_bits[15:8] : span_bits[7:0];
        w_fsel = fa[0];
        w_fok  = (fa < AW_S'(STORE_BYTES));
        if (r_s1_kind == lcdpw_pkg::K_FRAME) begin
            w_ix0 = fa[BANK_AW:1];
            w_ix1 = fa[BANK_AW:1];
        end else begin
            w_ix0 = a_even[BANK_AW:1];
            w_ix1 = a_odd[BANK_AW:1];
        end
    end

    // ---------------- stage 2: merge, write back, result
    assign w_cur0 = (r_fw0_v && (r_fw0_ix == r_s2_ix0)) ? r_fw0_d : w_rd0;
    assign w_cur1 = (r_fw1_v && (r_fw1_ix == r_s2_ix1)) ? r_fw1_d : w_rd1;
    assign w_new0 = (w_cur0 & ~r_s2_m0) | (r_s2_d0 & r_s2_m0);
    assign w_new1 = (w_cur1 & ~r_s2_m1) | (r_s2_d1 & r_s2_m1);
    assign w_we0  = (r_s2_kind == lcdpw_pkg::K_PIXEL) && (r_s2_m0 != 8'h00);
    assign w_we1  = (r_s2_kind == lcdpw_pkg::K_PIXEL) && (r_s2_m1 != 8'h00);

    assign w_bwe0 = r_clr_busy || w_we0;
    assign w_bwe1 = r_clr_busy || w_we1;
    assign w_bwa0 = r_clr_busy ? r_clr_ix : r_s2_ix0;
    assign w_bwa1 = r_clr_busy ? r_clr_ix : r_s2_ix1;
    assign w_bwd0 = r_clr_busy ? 8'h00 : w_new0;
    assign w_bwd1 = r_clr_busy ? 8'h00 : w_new1;

    always_comb begin
        w_push.valid = 1'b0;
        w_push.data  = r_s2_data;
        unique case (r_s2_kind)
            lcdpw_pkg::K_REG: w_push.valid = 1'b1;
            lcdpw_pkg::K_FRAME: begin
                w_push.valid = 1'b1;
                w_push.data  = r_s2_fok ? (r_s2_fsel ? w_cur1 : w_cur0) : 8'h00;
            end
            lcdpw_pkg::K_NONE, lcdpw_pkg::K_PIXEL: ;
        endcase
    end

    lcdpw_frame_bank #(.DEPTH(BANK_DEPTH), .AW(BANK_AW)) u_bank_even (
        .i_clk   (i_clk),
        .i_we    (w_bwe0),
        .i_waddr (w_bwa0),
        .i_wdata (w_bwd0),
        .i_raddr (w_ix0),
        .o_rdata (w_rd0)
    );

    lcdpw_frame_bank #(.DEPTH(BANK_DEPTH), .AW(BANK_AW)) u_bank_odd (
        .i_clk   (i_clk),
        .i_we    (w_bwe1),
        .i_waddr (w_bwa1),
        .i_wdata (w_bwd1),
        .i_raddr (w_ix1),
        .o_rdata (w_rd1)
    );

    lcdpw_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_count (w_fifo_cnt)
    );

    // queued plus in-flight results must fit in the output queue
    assign w_load = {1'b0, w_fifo_cnt}
        + (lcdpw_pkg::FIFO_CW + 1)'((r_s1_kind == lcdpw_pkg::K_REG)
                                    || (r_s1_kind == lcdpw_pkg::K_FRAME))
        + (lcdpw_pkg::FIFO_CW + 1)'((r_s2_kind == lcdpw_pkg::K_REG)
                                    || (r_s2_kind == lcdpw_pkg::K_FRAME));
    assign s_axis_tready = !r_clr_busy
        && (w_load < (lcdpw_pkg::FIFO_CW + 1)'(lcdpw_pkg::FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index    <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_func     <= '0;
            r_s1_kind  <= lcdpw_pkg::K_NONE;
            r_s2_kind  <= lcdpw_pkg::K_NONE;
            r_fw0_v    <= 1'b0;
            r_fw1_v    <= 1'b0;
            r_clr_busy <= 1'b1;
            r_clr_ix   <= '0;
        end else begin
            r_index   <= n_index;
            r_col     <= n_col;
            r_row     <= n_row;
            r_func    <= n_func;
            r_s1_kind <= n_s1_kind;
            r_s2_kind <= r_s1_kind;
            r_fw0_v   <= w_we0;
            r_fw1_v   <= w_we1;
            if (r_clr_busy) begin
                if (r_clr_ix == BANK_AW'(BANK_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
                r_clr_ix <= r_clr_ix + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_data  <= n_s1_data;
        r_s1_x0    <= w_x0;
        r_s1_y     <= r_row[4:0];
        r_s1_bits  <= w_bits;
        r_s1_en    <= w_en;
        r_s1_faddr <= w_faddr;
        r_s2_data  <= r_s1_data;
        r_s2_m0    <= w_m0;
        r_s2_m1    <= w_m1;
        r_s2_d0    <= w_d0;
        r_s2_d1    <= w_d1;
        r_s2_ix0   <= w_ix0;
        r_s2_ix1   <= w_ix1;
        r_s2_fsel  <= w_fsel;
        r_s2_fok   <= w_fok;
        r_fw0_ix   <= r_s2_ix0;
        r_fw1_ix   <= r_s2_ix1;
        r_fw0_d    <= w_new0;
        r_fw1_d    <= w_new1;
    end

    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.valid |-> ((w_fifo_cnt < lcdpw_pkg::FIFO_CW'(lcdpw_pkg::FIFO_DEPTH))
                          || (m_axis_tvalid && m_axis_tready)))
        else $error("output queue overflow");

    a_clear_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> ((r_s1_kind == lcdpw_pkg::K_NONE)
                        && (r_s2_kind == lcdpw_pkg::K_NONE) && !s_axis_tready))
        else $error("request in flight during clearing pass");

    a_pixel_span : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_kind == lcdpw_pkg::K_PIXEL) |-> ($countones({r_s2_m0, r_s2_m1}) <= 8))
        else $error("pixel write touches more than eight pixels");

endmodule

`default_nettype wire

// ===== tb/lcd_controller_pixel_writer_unit_tb.sv =====
// Self-checking testbench for lcd_controller_pixel_writer_unit.
// Needs lcdpw_pkg and the unit. It predicts register and frame-store effects
// per request and checks every read_data that comes out, in order.
`timescale 1ns / 100ps

module lcd_controller_pixel_writer_unit_tb;

    localparam int FRAME_WIDTH  = 192;
    localparam int COLUMN_LIMIT = 22;
    localparam int ROW_LIMIT    = 64;
    localparam int LINE_BYTES   = FRAME_WIDTH / 8;
    localparam int STORE_BYTES  = LINE_BYTES * lcdpw_pkg::LINES;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 400;

    localparam logic [1:0] CMD_UNUSED      = 2'd3;
    localparam logic [2:0] IDX_FIRST_SPARE = 3'd4;

    typedef struct {
        logic [1:0] cmd;
        logic       odd;
        logic [7:0] wdata;
        logic [9:0] faddr;
    } t_pw_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // write_data[7:0], frame_addr[17:8]
    logic [2:0]  s_axis_tuser = '0;   // cmd[1:0], port_odd[2]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // read_data[7:0]

    t_pw_req    pending_reqs[$];
    t_pw_req    drv_req;
    logic [7:0] read_data_expected[$];

    logic [7:0] index_q = '0;
    logic [7:0] column_q = '0;
    logic [7:0] row_q = '0;
    logic [7:0] function_q = '0;
    logic [7:0] frame_bytes [STORE_BYTES];

    logic in_fire = 1'b0;
    logic rx_hold = 1'b0;
    logic hold_go = 1'b0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   reqs_queued = 0;
    int   err_count = 0;
    int   cycle_count = 0;
    int   results_checked = 0;
    int   pixel_writes = 0;
    int   frame_reads = 0;

    lcd_controller_pixel_writer_unit #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .COLUMN_LIMIT (COLUMN_LIMIT),
        .ROW_LIMIT    (ROW_LIMIT)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic set_pixel(input int x, input int y, input logic on);
        int         byte_at;
        logic [7:0] mask;
        if (x < 0 || x >= FRAME_WIDTH) return;
        byte_at = y * LINE_BYTES + x / 8;
        if (byte_at >= STORE_BYTES) return;
        mask = 8'h80 >> (x % 8);
        if (on) frame_bytes[byte_at] = frame_bytes[byte_at] | mask;
        else frame_bytes[byte_at] = frame_bytes[byte_at] & ~mask;
    endtask

    task automatic write_pixel_byte(input logic [7:0] v);
        int col;
        int row;
        int y;
        int base;
        col = column_q;
        row = row_q;
        y = row % lcdpw_pkg::LINES;
        pixel_writes++;
        if (function_q[lcdpw_pkg::FUNC_MODE6_BIT]) begin
            if (col >= lcdpw_pkg::MODE6_FIRST_COL && col < COLUMN_LIMIT
                && row < ROW_LIMIT) begin
                base = (row / lcdpw_pkg::LINES) * lcdpw_pkg::HALF_SHIFT
                       + (col - lcdpw_pkg::MODE6_FIRST_COL) * 6;
                for (int k = 0; k < 6; k++) set_pixel(base + k, y, v[5 - k]);
            end
        end else begin
            if (col >= lcdpw_pkg::MODE8_FIRST_COL && col < COLUMN_LIMIT
                && row < ROW_LIMIT) begin
                base = (row / lcdpw_pkg::LINES) * lcdpw_pkg::HALF_SHIFT
                       + (col - lcdpw_pkg::MODE8_FIRST_COL) * 8;
                for (int k = 0; k < 8; k++)
                    set_pixel(base - lcdpw_pkg::MODE8_LEAD + k, y, v[7 - k]);
            end
        end
        if (function_q[lcdpw_pkg::FUNC_COL_STEP_BIT]) column_q = column_q + 8'd1;
        else row_q = row_q + 8'd1;
    endtask

    task automatic predict_request(input logic [1:0] cmd, input logic odd,
                                   input logic [7:0] wdata, input logic [9:0] faddr);
        case (cmd)
            lcdpw_pkg::CMD_BUS_READ: read_data_expected.push_back(odd ? 8'h00 : index_q);
            lcdpw_pkg::CMD_BUS_WRITE: begin
                if (!odd) begin
                    index_q = wdata;
                end else begin
                    case (index_q[2:0])
                        lcdpw_pkg::IDX_PIXEL:    write_pixel_byte(wdata);
                        lcdpw_pkg::IDX_COLUMN:   column_q = wdata;
                        lcdpw_pkg::IDX_ROW:      row_q = wdata;
                        lcdpw_pkg::IDX_FUNCTION: function_q = wdata;
                        default: ;
                    endcase
                end
            end
            lcdpw_pkg::CMD_FRAME_READ: begin
                frame_reads++;
                read_data_expected.push_back(faddr < STORE_BYTES ? frame_bytes[faddr] : 8'h00);
            end
            default: ;
        endcase
    endtask

    // sample at rising edge: output check first, then input prediction
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end else begin
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                if (read_data_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected result 0x%02h", m_axis_tdata));
                end else begin
                    if (m_axis_tdata !== read_data_expected[0])
                        report_mismatch($sformatf("read_data 0x%02h, expected 0x%02h",
                                                  m_axis_tdata, read_data_expected[0]));
                    void'(read_data_expected.pop_front());
                    results_checked++;
                end
            end
            in_fire = i_rst_n && s_axis_tvalid && s_axis_tready;
            if (in_fire)
                predict_request(s_axis_tuser[1:0], s_axis_tuser[2],
                                s_axis_tdata[7:0], s_axis_tdata[17:8]);
        end
    end

    always @(negedge i_clk) begin
        if (!s_axis_tvalid || in_fire) begin
            if (i_rst_n && pending_reqs.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                drv_req = pending_reqs.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {6'd0, drv_req.faddr, drv_req.wdata};
                s_axis_tuser  <= {drv_req.odd, drv_req.cmd};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= !rx_hold && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // long sink stall so the output queue fills and input backpressure shows
    initial begin
        wait (hold_go);
        @(negedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        rx_hold <= 1'b0;
    end

    task automatic push_req(input logic [1:0] cmd, input logic odd,
                            input logic [7:0] wdata, input logic [9:0] faddr);
        t_pw_req r;
        r.cmd = cmd;
        r.odd = odd;
        r.wdata = wdata;
        r.faddr = faddr;
        pending_reqs.push_back(r);
        reqs_queued++;
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [7:0] v);
        push_req(lcdpw_pkg::CMD_BUS_WRITE, 1'b0, {5'd0, idx}, 10'($urandom));
        push_req(lcdpw_pkg::CMD_BUS_WRITE, 1'b1, v, 10'($urandom));
    endtask

    task automatic frame_read(input logic [9:0] a);
        push_req(lcdpw_pkg::CMD_FRAME_READ, 1'($urandom), 8'($urandom), a);
    endtask

    task automatic push_directed();
        push_req(lcdpw_pkg::CMD_BUS_READ, 1'b0, 8'hA5, 10'h3FF);
        push_req(lcdpw_pkg::CMD_BUS_READ, 1'b1, 8'h5A, 10'h000);
        frame_read(10'h3FF);
        reg_write(lcdpw_pkg::IDX_COLUMN, 8'd4);       // left edge, lead pixels clipped
        push_req(lcdpw_pkg::CMD_BUS_WRITE, 1'b0, {5'd0, lcdpw_pkg::IDX_PIXEL}, 10'd0);
        push_req(lcdpw_pkg::CMD_BUS_WRITE, 1'b1, 8'hFF, 10'd0);
        frame_read(10'd0);
        reg_write(lcdpw_pkg::IDX_ROW, 8'd63);
        reg_write(lcdpw_pkg::IDX_COLUMN, 8'd21);      // right half past frame width
        push_req(lcdpw_pkg::CMD_BUS_WRITE, 1'b0, {5'd0, lcdpw_pkg::IDX_PIXEL}, 10'd0);
        push_req(lcdpw_pkg::CMD_BUS_WRITE, 1'b1, 8'h5A, 10'd0);
        push_req(lcdpw_pkg::CMD_BUS_WRITE, 1'b1, 8'h5A, 10'd0); // row now out of window
        reg_write(lcdpw_pkg::IDX_FUNCTION, 8'hC0);    // 6-pixel mode, column step
        reg_write(lcdpw_pkg::IDX_COLUMN, 8'd6);
        reg_write(lcdpw_pkg::IDX_ROW, 8'd31);
        push_req(lcdpw_pkg::CMD_BUS_WRITE, 1'b0, {5'd0, lcdpw_pkg::IDX_PIXEL}, 10'd0);
        push_req(lcdpw_pkg::CMD_BUS_WRITE, 1'b1, 8'h3F, 10'd0);
        frame_read(10'(31 * LINE_BYTES));
        reg_write(IDX_FIRST_SPARE, 8'hAA);            // unused index
        push_req(CMD_UNUSED, 1'b1, 8'hFF, 10'h3FF);
        push_req(lcdpw_pkg::CMD_BUS_READ, 1'b0, 8'h00, 10'd0);
        frame_read(10'(STORE_BYTES - 1));
        frame_read(10'(STORE_BYTES));
    endtask

    task automatic push_random(input int n_items);
        int target;
        int pick;
        int row;
        int burst;
        target = reqs_queued + n_items;
        while (reqs_queued < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                if ($urandom_range(0, 1)) reg_write(lcdpw_pkg::IDX_FUNCTION, 8'($urandom));
                if ($urandom_range(0, 4) != 0)
                    reg_write(lcdpw_pkg::IDX_COLUMN,
                              8'($urandom_range(lcdpw_pkg::MODE8_FIRST_COL,
                                                COLUMN_LIMIT - 1)));
                else
                    reg_write(lcdpw_pkg::IDX_COLUMN, 8'($urandom));
                row = ($urandom_range(0, 4) != 0) ? $urandom_range(0, ROW_LIMIT - 1)
                                                  : $urandom_range(0, 255);
                reg_write(lcdpw_pkg::IDX_ROW, 8'(row));
                push_req(lcdpw_pkg::CMD_BUS_WRITE, 1'b0, {5'd0, lcdpw_pkg::IDX_PIXEL},
                         10'($urandom));
                burst = $urandom_range(1, 8);
                for (int k = 0; k < burst; k++)
                    push_req(lcdpw_pkg::CMD_BUS_WRITE, 1'b1, 8'($urandom), 10'($urandom));
                if ($urandom_range(0, 1))
                    frame_read(10'((row % lcdpw_pkg::LINES) * LINE_BYTES +
                                   $urandom_range(0, LINE_BYTES - 1)));
            end else if (pick < 70) begin
                burst = $urandom_range(1, 3);
                for (int k = 0; k < burst; k++) begin
                    if ($urandom_range(0, 9) != 0)
                        frame_read(10'($urandom_range(0, STORE_BYTES - 1)));
                    else
                        frame_read(10'($urandom_range(STORE_BYTES, 1023)));
                end
            end else if (pick < 85) begin
                if ($urandom_range(0, 1))
                    push_req(lcdpw_pkg::CMD_BUS_WRITE, 1'b0, 8'($urandom), 10'($urandom));
                push_req(lcdpw_pkg::CMD_BUS_READ, 1'($urandom), 8'($urandom), 10'($urandom));
            end else begin
                push_req(2'($urandom), 1'($urandom), 8'($urandom), 10'($urandom));
            end
        end
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || s_axis_tvalid || read_data_expected.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 10;
        recv_idle_pct = 88;
        push_directed();
        push_random(170);
        drain();

        send_idle_pct = 88;
        recv_idle_pct = 10;
        push_random(170);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_go = 1'b1;
        push_random(170);
        drain();
        repeat (10) @(posedge i_clk);

        $display("%0d requests sent, %0d results checked (%0d display fetches)",
                 reqs_queued, results_checked, frame_reads);
        $display("%0d pixel writes in both modes, %0d mismatches", pixel_writes, err_count);
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
